FILE: src/odd_prime_table_sieve_unit_defines.svh
// Assertion macros shared by the sieve unit. They expect clk and rst_n in scope.
`ifndef ODD_PRIME_TABLE_SIEVE_UNIT_DEFINES_SVH
`define ODD_PRIME_TABLE_SIEVE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OPTS_CHECK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OPTS_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/opts_pkg.sv
package opts_pkg;

  localparam int unsigned LIMIT_W         = 18;
  localparam int unsigned INDEX_W         = 15;
  localparam int unsigned COUNT_OUT_W     = 16;
  localparam int unsigned CFG_DW          = 32;
  localparam int unsigned CFG_AW          = 2;
  localparam int unsigned LIMIT_FIELD_MAX = 262143;
  localparam int unsigned LIMIT_MAX_DEF   = 262143;
  localparam int unsigned PRIME_SLOTS_DEF = 32768;

  // Odd sieving primes stay below 2**9 since the limit field is 18 bits wide.
  localparam int unsigned P_W  = 10;
  localparam int unsigned SQ_W = 2 * P_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 18'h3FFFF;
  localparam logic [CFG_AW-1:0]  REG_LIMIT   = 2'd0;

  typedef logic [4:0] upc_t;

  localparam upc_t U_IDLE  = 5'd0;
  localparam upc_t U_DISP  = 5'd1;
  localparam upc_t U_INIT  = 5'd2;
  localparam upc_t U_CHK   = 5'd3;
  localparam upc_t U_CLR   = 5'd4;
  localparam upc_t U_PINIT = 5'd5;
  localparam upc_t U_PSQ   = 5'd6;
  localparam upc_t U_PTST  = 5'd7;
  localparam upc_t U_PCHK  = 5'd8;
  localparam upc_t U_MARK  = 5'd9;
  localparam upc_t U_PNXT  = 5'd10;
  localparam upc_t U_CINIT = 5'd11;
  localparam upc_t U_CRD   = 5'd12;
  localparam upc_t U_CTST  = 5'd13;
  localparam upc_t U_FIN   = 5'd14;
  localparam upc_t U_Q0    = 5'd15;
  localparam upc_t U_Q1    = 5'd16;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_INIT,
    OP_CLR,
    OP_PINIT,
    OP_SQ,
    OP_MSTART,
    OP_MARK,
    OP_PINC,
    OP_CINIT,
    OP_CREAD,
    OP_CTEST,
    OP_FIN,
    OP_QREAD,
    OP_RESULT
  } uop_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_BUILT,
    C_SMALL,
    C_CLR_MORE,
    C_SQ_GT,
    C_MARKED,
    C_MARK_MORE,
    C_SCAN_MORE
  } ucond_t;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    upc_t   target;
  } ucw_t;

  // Control store: when the condition holds the sequencer jumps to target,
  // otherwise it steps to the next word.
  function automatic ucw_t ucode_rom(input upc_t pc);
    ucw_t w;
    unique case (pc)
      U_IDLE:  w = '{op: OP_IDLE,   cond: C_NO_START,  target: U_IDLE};
      U_DISP:  w = '{op: OP_QREAD,  cond: C_BUILT,     target: U_Q1};
      U_INIT:  w = '{op: OP_INIT,   cond: C_NEVER,     target: U_IDLE};
      U_CHK:   w = '{op: OP_NOP,    cond: C_SMALL,     target: U_FIN};
      U_CLR:   w = '{op: OP_CLR,    cond: C_CLR_MORE,  target: U_CLR};
      U_PINIT: w = '{op: OP_PINIT,  cond: C_NEVER,     target: U_IDLE};
      U_PSQ:   w = '{op: OP_SQ,     cond: C_NEVER,     target: U_IDLE};
      U_PTST:  w = '{op: OP_NOP,    cond: C_SQ_GT,     target: U_CINIT};
      U_PCHK:  w = '{op: OP_MSTART, cond: C_MARKED,    target: U_PNXT};
      U_MARK:  w = '{op: OP_MARK,   cond: C_MARK_MORE, target: U_MARK};
      U_PNXT:  w = '{op: OP_PINC,   cond: C_ALWAYS,    target: U_PSQ};
      U_CINIT: w = '{op: OP_CINIT,  cond: C_NEVER,     target: U_IDLE};
      U_CRD:   w = '{op: OP_CREAD,  cond: C_NEVER,     target: U_IDLE};
      U_CTST:  w = '{op: OP_CTEST,  cond: C_SCAN_MORE, target: U_CRD};
      U_FIN:   w = '{op: OP_FIN,    cond: C_NEVER,     target: U_IDLE};
      U_Q0:    w = '{op: OP_QREAD,  cond: C_NEVER,     target: U_IDLE};
      U_Q1:    w = '{op: OP_RESULT, cond: C_ALWAYS,    target: U_IDLE};
      default: w = '{op: OP_NOP,    cond: C_ALWAYS,    target: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: src/opts_ram.sv
module opts_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/odd_prime_table_sieve_unit.sv
// Query after the table is built: U_DISP reads the prime store, U_Q1 registers result and
// strobe; busy drops with the strobe, so queries never overlap, and the receiver cannot stall.
// Build, run by the first query after reset or a limit write, with t = min(limit, LIMIT_MAX):
// clear marks up to t, mark multiples of each unmarked odd p up to sqrt(t), scan odd entries.
// Reset (rst_n low, synchronous) clears the sequencer, count and built flag, sets the limit to
// all ones; each build clears the mark store, so there is no clearing pass after reset.
module odd_prime_table_sieve_unit #(
  parameter int unsigned LIMIT_MAX   = opts_pkg::LIMIT_MAX_DEF,
  parameter int unsigned PRIME_SLOTS = opts_pkg::PRIME_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [opts_pkg::INDEX_W-1:0]       in_index,
  output logic                               out_strobe,
  output logic [opts_pkg::LIMIT_W-1:0]       out_prime,
  output logic                               out_found,
  output logic [opts_pkg::COUNT_OUT_W-1:0]   out_prime_count,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [opts_pkg::CFG_AW-1:0]        paddr,
  input  logic [opts_pkg::CFG_DW-1:0]        pwdata,
  output logic [opts_pkg::CFG_DW-1:0]        prdata,
  output logic                               pready
);
  import opts_pkg::*;
  `include "odd_prime_table_sieve_unit_defines.svh"

  localparam int unsigned MARK_TOP   = (LIMIT_MAX < LIMIT_FIELD_MAX) ? LIMIT_MAX
                                                                     : LIMIT_FIELD_MAX;
  localparam int unsigned MARK_DEPTH = MARK_TOP / 2 + 1;
  localparam int unsigned MAW        = $clog2(MARK_DEPTH);
  localparam int unsigned PSW        = $clog2(PRIME_SLOTS);
  localparam int unsigned CNT_W      = $clog2(PRIME_SLOTS + 1);

  // Sequencer and control state.
  upc_t               upc_r, upc_nxt;
  ucw_t               uw;
  logic               jump;
  logic [LIMIT_W-1:0] limit_r;
  logic               built_r, built_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_strobe_r;

  // Datapath registers.
  logic [INDEX_W-1:0]     idx_r, idx_nxt;
  logic [LIMIT_W-1:0]     top_r, top_nxt;
  logic [LIMIT_W-1:0]     a_r, a_nxt;
  logic [P_W-1:0]         p_r, p_nxt;
  logic [SQ_W-1:0]        sq_r, sq_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic [LIMIT_W-1:0]     out_prime_r, out_prime_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [COUNT_OUT_W-1:0] out_count_r, out_count_nxt;

  logic [LIMIT_W-1:0] top_m1;
  logic [LIMIT_W-1:0] ha;
  logic [LIMIT_W-1:0] a_sum;
  logic               found_now;
  logic               cfg_wr;

  // Mark store holds one bit per odd number: entry a stands for 2a+1.
  logic           mark_we, mark_re, mark_wdata, mark_rdata;
  logic [MAW-1:0] mark_waddr, mark_raddr;

  logic               ps_we, ps_re;
  logic [PSW-1:0]     ps_waddr, ps_raddr;
  logic [LIMIT_W-1:0] ps_wdata, ps_rdata;

  opts_ram #(.WIDTH(1), .DEPTH(MARK_DEPTH)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (mark_re),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

  opts_ram #(.WIDTH(LIMIT_W), .DEPTH(PRIME_SLOTS)) u_prime_ram (
    .clk   (clk),
    .we    (ps_we),
    .waddr (ps_waddr),
    .wdata (ps_wdata),
    .re    (ps_re),
    .raddr (ps_raddr),
    .rdata (ps_rdata)
  );

  assign cfg_wr = psel && penable && pwrite && (paddr == REG_LIMIT);
  assign pready = 1'b1;
  assign prdata = (paddr == REG_LIMIT) ? CFG_DW'(limit_r) : '0;

  // Highest mark entry for the current top: odd m <= top means (m-1)/2 <= (top-1)/2.
  assign top_m1    = top_r - LIMIT_W'(1);
  assign ha        = {1'b0, top_m1[LIMIT_W-1:1]};
  assign a_sum     = a_r + LIMIT_W'(p_r);
  assign found_now = (32'(idx_r) < 32'(count_r));

  assign ps_waddr = n_r[PSW-1:0];
  assign ps_wdata = LIMIT_W'({a_r, 1'b1});
  assign ps_raddr = PSW'(idx_r);

  always_comb begin
    uw            = ucode_rom(upc_r);
    idx_nxt       = idx_r;
    top_nxt       = top_r;
    a_nxt         = a_r;
    p_nxt         = p_r;
    sq_nxt        = sq_r;
    n_nxt         = n_r;
    count_nxt     = count_r;
    built_nxt     = built_r;
    out_prime_nxt = out_prime_r;
    out_found_nxt = out_found_r;
    out_count_nxt = out_count_r;
    mark_we       = 1'b0;
    mark_wdata    = 1'b0;
    mark_waddr    = a_r[MAW-1:0];
    mark_re       = 1'b0;
    mark_raddr    = a_r[MAW-1:0];
    ps_we         = 1'b0;
    ps_re         = 1'b0;

    unique case (uw.op)
      OP_IDLE: begin
        if (start) begin
          idx_nxt = in_index;
        end
      end
      OP_INIT: begin
        top_nxt = (limit_r > LIMIT_W'(MARK_TOP)) ? LIMIT_W'(MARK_TOP) : limit_r;
        a_nxt   = '0;
        n_nxt   = '0;
      end
      OP_CLR: begin
        mark_we = 1'b1;
        a_nxt   = a_r + LIMIT_W'(1);
      end
      OP_PINIT: begin
        p_nxt = P_W'(3);
      end
      OP_SQ: begin
        sq_nxt     = SQ_W'(p_r) * SQ_W'(p_r);
        mark_re    = 1'b1;
        mark_raddr = MAW'(p_r >> 1);
      end
      OP_MSTART: begin
        a_nxt = LIMIT_W'(sq_r >> 1);
      end
      OP_MARK: begin
        mark_we    = 1'b1;
        mark_wdata = 1'b1;
        a_nxt      = a_sum;
      end
      OP_PINC: begin
        p_nxt = p_r + P_W'(2);
      end
      OP_CINIT: begin
        a_nxt = LIMIT_W'(1);
      end
      OP_CREAD: begin
        mark_re = 1'b1;
      end
      OP_CTEST: begin
        a_nxt = a_r + LIMIT_W'(1);
        if (!mark_rdata) begin
          ps_we = 1'b1;
          n_nxt = n_r + CNT_W'(1);
        end
      end
      OP_FIN: begin
        count_nxt = n_r;
        built_nxt = 1'b1;
      end
      OP_QREAD: begin
        ps_re = 1'b1;
      end
      OP_RESULT: begin
        out_prime_nxt = found_now ? ps_rdata : '0;
        out_found_nxt = found_now;
        out_count_nxt = COUNT_OUT_W'(count_r);
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase

    // A new limit invalidates the table.
    if (cfg_wr) begin
      built_nxt = 1'b0;
    end

    unique case (uw.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_START:  jump = !start;
      C_BUILT:     jump = built_r;
      C_SMALL:     jump = (top_r < LIMIT_W'(3));
      C_CLR_MORE:  jump = (a_r < ha);
      C_SQ_GT:     jump = (sq_r > SQ_W'(top_r));
      C_MARKED:    jump = mark_rdata;
      C_MARK_MORE: jump = (a_sum <= ha);
      C_SCAN_MORE: jump = (a_r < ha) && (n_nxt < CNT_W'(PRIME_SLOTS));
      default:     jump = 1'b0;
    endcase

    upc_nxt = jump ? uw.target : upc_t'(upc_r + upc_t'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r        <= U_IDLE;
      limit_r      <= LIMIT_RESET;
      built_r      <= 1'b0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      upc_r        <= upc_nxt;
      built_r      <= built_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= (uw.op == OP_RESULT);
      if (cfg_wr) begin
        limit_r <= pwdata[LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    top_r       <= top_nxt;
    a_r         <= a_nxt;
    p_r         <= p_nxt;
    sq_r        <= sq_nxt;
    n_r         <= n_nxt;
    out_prime_r <= out_prime_nxt;
    out_found_r <= out_found_nxt;
    out_count_r <= out_count_nxt;
  end

  assign busy            = (upc_r != U_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_prime       = out_prime_r;
  assign out_found       = out_found_r;
  assign out_prime_count = out_count_r;

  `OPTS_CHECK_NEXT(a_result_follows, upc_r == U_Q1, out_strobe_r, "result beat missing")
  `OPTS_CHECK_NOW(a_strobe_source, out_strobe_r, $past(upc_r) == U_Q1, "stray result beat")
  `OPTS_CHECK_NOW(a_found_odd, out_strobe_r && out_found_r, out_prime_r[0], "even prime given")
  `OPTS_CHECK_NOW(a_mark_bound, mark_we, a_r <= ha, "mark write beyond the limit")
  `OPTS_CHECK_NOW(a_count_bound, built_r, count_r <= CNT_W'(PRIME_SLOTS), "count overflow")

endmodule

FILE: tb/odd_prime_table_sieve_unit_tb.sv
module odd_prime_table_sieve_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import opts_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES = 4000000;

  typedef struct packed {
    logic [LIMIT_W-1:0]     prime;
    logic                   found;
    logic [COUNT_OUT_W-1:0] count;
  } sieve_answer_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [INDEX_W-1:0]     in_index;
  logic                   out_strobe;
  logic [LIMIT_W-1:0]     out_prime;
  logic                   out_found;
  logic [COUNT_OUT_W-1:0] out_prime_count;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CFG_AW-1:0]      paddr;
  logic [CFG_DW-1:0]      pwdata;
  logic [CFG_DW-1:0]      prdata;
  logic                   pready;

  // Local copy of the block's state.
  logic [LIMIT_W-1:0] sieve_limit;
  bit                 table_ready;
  int unsigned        prime_total;
  bit                 composite_marks [0:LIMIT_MAX_DEF];
  logic [LIMIT_W-1:0] prime_tbl [0:PRIME_SLOTS_DEF-1];

  sieve_answer_t pending_answers [$];
  int unsigned   mismatch_count;
  int unsigned   idle_cycles;
  bit            gaps_on;

  odd_prime_table_sieve_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_index        (in_index),
    .out_strobe      (out_strobe),
    .out_prime       (out_prime),
    .out_found       (out_found),
    .out_prime_count (out_prime_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic void sieve_odd_primes();
    int unsigned top;
    int unsigned p;
    int unsigned m;
    int unsigned n;
    top = sieve_limit;
    if (top > LIMIT_MAX_DEF) top = LIMIT_MAX_DEF;
    for (m = 0; m <= top; m++) composite_marks[m] = 1'b0;
    for (p = 2; p * p <= top; p++) begin
      if (!composite_marks[p]) begin
        for (m = p * p; m <= top; m += p) composite_marks[m] = 1'b1;
      end
    end
    n = 0;
    for (p = 3; p <= top; p += 2) begin
      if (composite_marks[p]) continue;
      if (n >= PRIME_SLOTS_DEF) break;
      prime_tbl[n] = LIMIT_W'(p);
      n++;
    end
    prime_total = n;
    table_ready = 1'b1;
  endfunction

  function automatic sieve_answer_t lookup_odd_prime(input logic [INDEX_W-1:0] idx);
    sieve_answer_t a;
    if (!table_ready) sieve_odd_primes();
    a = '0;
    if (idx < prime_total) begin
      a.prime = prime_tbl[idx];
      a.found = 1'b1;
    end
    a.count = COUNT_OUT_W'(prime_total);
    return a;
  endfunction

  // Mostly ranks inside the table, some right at its end, the rest anywhere.
  function automatic logic [INDEX_W-1:0] pick_index();
    int unsigned n;
    int unsigned roll;
    n = table_ready ? prime_total : 0;
    roll = $urandom_range(99);
    if (n > 0 && roll < 60) return INDEX_W'($urandom_range(0, n - 1));
    if (roll < 75) return INDEX_W'(n + $urandom_range(3) - 1);
    return INDEX_W'($urandom);
  endfunction

  always @(posedge clk) begin
    sieve_answer_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: result with no query waiting: prime %0d found %0d count %0d",
                   $time, out_prime, out_found, out_prime_count);
          mismatch_count++;
        end else begin
          want = pending_answers.pop_front();
          if (out_prime !== want.prime) begin
            $display("%0t: prime expected %0d, got %0d", $time, want.prime, out_prime);
            mismatch_count++;
          end
          if (out_found !== want.found) begin
            $display("%0t: found expected %0d, got %0d", $time, want.found, out_found);
            mismatch_count++;
          end
          if (out_prime_count !== want.count) begin
            $display("%0t: prime_count expected %0d, got %0d",
                     $time, want.count, out_prime_count);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) pending_answers.push_back(lookup_odd_prime(in_index));
      if (out_strobe || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Called and returns at a falling edge.
  task automatic send_query(input logic [INDEX_W-1:0] idx);
    in_index = idx;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
    if (gaps_on && $urandom_range(99) < 25) repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic settle();
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes the limit register once the block is idle, then reads it back.
  task automatic set_limit(input logic [CFG_DW-1:0] data);
    settle();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = REG_LIMIT;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sieve_limit = data[LIMIT_W-1:0];
    table_ready = 1'b0;
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DW'(sieve_limit)) begin
      $display("%0t: limit readback expected %0d, got %0d", $time, sieve_limit, prdata);
      mismatch_count++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // The first query after reset builds the full table at the reset limit.
  task automatic test_reset_limit();
    gaps_on = 1'b1;
    send_query('0);
    send_query(INDEX_W'(prime_total - 1));
    send_query(INDEX_W'(prime_total));
    send_query('1);
    send_query(INDEX_W'(16384));
    send_query(INDEX_W'(1));
    repeat (250) send_query(pick_index());
  endtask

  task automatic test_small_limits();
    set_limit(CFG_DW'(2));
    send_query('0);
    set_limit(CFG_DW'(3));
    send_query('0);
    send_query(INDEX_W'(1));
    // Nine is the square of a sieving prime and sits right on the limit.
    set_limit(CFG_DW'(9));
    send_query(INDEX_W'(2));
    send_query(INDEX_W'(3));
    set_limit(CFG_DW'(25));
    send_query(INDEX_W'(7));
    send_query(INDEX_W'(8));
    set_limit(CFG_DW'(0));
    send_query('0);
    set_limit(CFG_DW'(1));
    send_query('1);
    // Bits above the register width are dropped.
    set_limit(32'hFFFC_0007);
    send_query(INDEX_W'(2));
    // A second write with no query between them; only the last one counts.
    set_limit(CFG_DW'(LIMIT_MAX_DEF));
    set_limit(CFG_DW'(4));
    send_query('0);
    send_query(INDEX_W'(1));
  endtask

  task automatic test_random_limits();
    int unsigned sent;
    int unsigned n;
    int unsigned roll;
    logic [LIMIT_W-1:0] lim;
    sent = 0;
    while (sent < 1000) begin
      roll = $urandom_range(99);
      if (roll < 70) lim = LIMIT_W'($urandom_range(0, 600));
      else if (roll < 90) lim = LIMIT_W'($urandom_range(600, 5000));
      else lim = LIMIT_W'($urandom_range(5000, 20000));
      set_limit(($urandom & ~CFG_DW'(LIMIT_FIELD_MAX)) | CFG_DW'(lim));
      gaps_on = ($urandom_range(99) < 70);
      n = $urandom_range(20, 80);
      repeat (n) send_query(pick_index());
      sent += n;
    end
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    set_limit(CFG_DW'(1000));
    repeat (250) send_query(pick_index());
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_index = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = REG_LIMIT;
    pwdata = '0;
    sieve_limit = LIMIT_RESET;
    table_ready = 1'b0;
    prime_total = 0;
    mismatch_count = 0;
    idle_cycles = 0;
    gaps_on = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_limit();
    test_small_limits();
    test_random_limits();
    test_back_to_back();

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/opts_pkg.sv
src/opts_ram.sv
src/odd_prime_table_sieve_unit.sv
tb/odd_prime_table_sieve_unit_tb.sv
